@@ rtl/scd_pkg.sv @@
`timescale 1ns / 1ps
// scd_pkg: types, codes and constants shared by the serial command decoder
// no dependencies; used by every other file of the block

package scd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 17;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 2;
  localparam int unsigned ProdW  = 21;

  localparam logic [ByteW-1:0] ChSemi  = 8'h3B;
  localparam logic [ByteW-1:0] ChSet   = 8'h53;
  localparam logic [ByteW-1:0] ChGet   = 8'h47;
  localparam logic [ByteW-1:0] ChFreq  = 8'h46;
  localparam logic [ByteW-1:0] ChAmp   = 8'h41;
  localparam logic [ByteW-1:0] ChLimit = 8'h4C;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  localparam logic [ValueW-1:0] AccMax    = 17'd131071;
  localparam logic [ValueW-1:0] FreqMin   = 17'd100;
  localparam logic [ValueW-1:0] FreqMax   = 17'd100000;
  localparam logic [ValueW-1:0] FreqReset = 17'd200;
  localparam logic [CfgW-1:0]   AmpReset  = 16'd1000;
  localparam logic [CfgW-1:0]   LimReset  = 16'd2000;

  localparam logic [PosW-1:0] PosFirst  = 2'd0;
  localparam logic [PosW-1:0] PosSecond = 2'd1;
  localparam logic [PosW-1:0] PosRest   = 2'd2;

  typedef enum logic [2:0] {
    KIND_FREQ_SET      = 3'd0,
    KIND_FREQ_REJECTED = 3'd1,
    KIND_SET_AMP       = 3'd2,
    KIND_SET_LIMIT     = 3'd3,
    KIND_GET_FREQ      = 3'd4,
    KIND_GET_AMP       = 3'd5,
    KIND_GET_LIMIT     = 3'd6,
    KIND_FORMAT_ERROR  = 3'd7
  } reply_kind_e;

  typedef enum logic {
    REG_AMPLITUDE = 1'b0,
    REG_LIMIT     = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] amplitude_mv;
    logic [CfgW-1:0] upper_limit_hz;
  } cfg_t;

  typedef struct packed {
    reply_kind_e       kind;
    logic [ValueW-1:0] value;
    logic              synth_write;
    logic [ValueW-1:0] synth_frequency;
  } reply_t;

endpackage

@@ rtl/scd_rx_if.sv @@
`timescale 1ns / 1ps
// scd_rx_if: received character channel, valid/ready handshake
// depends on scd_pkg for the character width

interface scd_rx_if;
  logic                       valid;
  logic                       ready;
  logic [scd_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/scd_reply_if.sv @@
`timescale 1ns / 1ps
// scd_reply_if: reply channel, valid/ready handshake
// depends on scd_pkg for the field widths

interface scd_reply_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 reply_kind;
  logic [scd_pkg::ValueW-1:0] reply_value;
  logic                       synth_write;
  logic [scd_pkg::ValueW-1:0] synth_frequency;

  modport source (output valid, output reply_kind, output reply_value,
                  output synth_write, output synth_frequency, input ready);
  modport sink   (input valid, input reply_kind, input reply_value,
                  input synth_write, input synth_frequency, output ready);
endinterface

@@ rtl/scd_apb_regs.sv @@
`timescale 1ns / 1ps
// scd_apb_regs: apb register file holding amplitude and upper limit
// depends on scd_pkg

module scd_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scd_pkg::AddrW-1:0]   paddr,
  input  logic [scd_pkg::DataW-1:0]   pwdata,
  output logic [scd_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output scd_pkg::cfg_t               cfg_o
);

  logic [scd_pkg::CfgW-1:0] amp_q, amp_d;
  logic [scd_pkg::CfgW-1:0] lim_q, lim_d;
  logic                     wr_en;
  scd_pkg::reg_idx_e        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = scd_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    amp_d = amp_q;
    lim_d = lim_q;
    if (wr_en) begin
      unique case (idx)
        scd_pkg::REG_AMPLITUDE: amp_d = pwdata[scd_pkg::CfgW-1:0];
        scd_pkg::REG_LIMIT:     lim_d = pwdata[scd_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      scd_pkg::REG_AMPLITUDE: prdata = {{(scd_pkg::DataW-scd_pkg::CfgW){1'b0}}, amp_q};
      scd_pkg::REG_LIMIT:     prdata = {{(scd_pkg::DataW-scd_pkg::CfgW){1'b0}}, lim_q};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q <= scd_pkg::AmpReset;
      lim_q <= scd_pkg::LimReset;
    end else begin
      amp_q <= amp_d;
      lim_q <= lim_d;
    end
  end

  assign cfg_o.amplitude_mv   = amp_q;
  assign cfg_o.upper_limit_hz = lim_q;

endmodule

@@ rtl/scd_decode.sv @@
`timescale 1ns / 1ps
// scd_decode: command letters, saturating digit accumulator, stored frequency
// and the reply decode on ';'; depends on scd_pkg

module scd_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [scd_pkg::ByteW-1:0]   byte_i,
  input  scd_pkg::cfg_t               cfg_i,
  output logic                        is_end_o,
  output scd_pkg::reply_t             reply_o
);

  logic [scd_pkg::PosW-1:0]   pos_q, pos_d;
  logic [scd_pkg::ByteW-1:0]  cmd_q, cmd_d;
  logic [scd_pkg::ByteW-1:0]  tgt_q, tgt_d;
  logic [scd_pkg::ValueW-1:0] acc_q, acc_d;
  logic [scd_pkg::ValueW-1:0] freq_q, freq_d;

  logic                       is_digit;
  logic [3:0]                 digit;
  logic [scd_pkg::ProdW-1:0]  acc_next;
  logic [scd_pkg::ByteW-1:0]  cmd_eff, tgt_eff;
  logic                       freq_ok;
  logic                       set_freq;

  assign is_end_o = (byte_i == scd_pkg::ChSemi);
  assign is_digit = (byte_i >= scd_pkg::ChZero) && (byte_i <= scd_pkg::ChNine);
  assign digit    = 4'(byte_i - scd_pkg::ChZero);
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                  + {{(scd_pkg::ProdW-4){1'b0}}, digit};

  assign cmd_eff = (pos_q == scd_pkg::PosFirst) ? scd_pkg::ChSemi : cmd_q;
  assign tgt_eff = (pos_q == scd_pkg::PosFirst || pos_q == scd_pkg::PosSecond)
                 ? scd_pkg::ChSemi : tgt_q;
  assign freq_ok = (acc_q >= scd_pkg::FreqMin) && (acc_q <= scd_pkg::FreqMax);

  // reply decode
  always_comb begin
    reply_o.kind            = scd_pkg::KIND_FORMAT_ERROR;
    reply_o.value           = '0;
    reply_o.synth_write     = 1'b0;
    reply_o.synth_frequency = '0;
    set_freq                = 1'b0;
    if (cmd_eff == scd_pkg::ChSet) begin
      case (tgt_eff)
        scd_pkg::ChFreq: begin
          set_freq                = freq_ok;
          reply_o.kind            = freq_ok ? scd_pkg::KIND_FREQ_SET
                                            : scd_pkg::KIND_FREQ_REJECTED;
          reply_o.value           = freq_ok ? acc_q : freq_q;
          reply_o.synth_write     = 1'b1;
          reply_o.synth_frequency = freq_ok ? acc_q : freq_q;
        end
        scd_pkg::ChAmp:   reply_o.kind = scd_pkg::KIND_SET_AMP;
        scd_pkg::ChLimit: reply_o.kind = scd_pkg::KIND_SET_LIMIT;
        default: ;
      endcase
    end else if (cmd_eff == scd_pkg::ChGet) begin
      case (tgt_eff)
        scd_pkg::ChFreq: begin
          reply_o.kind  = scd_pkg::KIND_GET_FREQ;
          reply_o.value = freq_q;
        end
        scd_pkg::ChAmp: begin
          reply_o.kind  = scd_pkg::KIND_GET_AMP;
          reply_o.value = {1'b0, cfg_i.amplitude_mv};
        end
        scd_pkg::ChLimit: begin
          reply_o.kind  = scd_pkg::KIND_GET_LIMIT;
          reply_o.value = {1'b0, cfg_i.upper_limit_hz};
        end
        default: ;
      endcase
    end
  end

  // command state update
  always_comb begin
    pos_d  = pos_q;
    cmd_d  = cmd_q;
    tgt_d  = tgt_q;
    acc_d  = acc_q;
    freq_d = freq_q;
    if (step_i) begin
      if (is_end_o) begin
        pos_d = scd_pkg::PosFirst;
        cmd_d = '0;
        tgt_d = '0;
        acc_d = '0;
        if (set_freq) begin
          freq_d = acc_q;
        end
      end else begin
        if (is_digit) begin
          acc_d = (acc_next[scd_pkg::ProdW-1:scd_pkg::ValueW] != '0)
                ? scd_pkg::AccMax : acc_next[scd_pkg::ValueW-1:0];
        end
        if (pos_q == scd_pkg::PosFirst) begin
          cmd_d = byte_i;
        end
        if (pos_q == scd_pkg::PosSecond) begin
          tgt_d = byte_i;
        end
        if (pos_q != scd_pkg::PosRest) begin
          pos_d = pos_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= scd_pkg::PosFirst;
      cmd_q  <= '0;
      tgt_q  <= '0;
      acc_q  <= '0;
      freq_q <= scd_pkg::FreqReset;
    end else begin
      pos_q  <= pos_d;
      cmd_q  <= cmd_d;
      tgt_q  <= tgt_d;
      acc_q  <= acc_d;
      freq_q <= freq_d;
    end
  end

`ifndef SYNTHESIS
  a_freq_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (freq_q >= scd_pkg::FreqMin) && (freq_q <= scd_pkg::FreqMax))
    else $error("stored frequency out of range");

  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != 2'd3)
    else $error("character position beyond saturation");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_end_o |=> (pos_q == scd_pkg::PosFirst) && (acc_q == '0))
    else $error("command state not cleared after end of command");

  a_freq_only_on_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i && is_end_o) |=> $stable(freq_q))
    else $error("frequency changed outside a set command");
`endif

endmodule

@@ rtl/serial_command_decoder.sv @@
`timescale 1ns / 1ps
// serial_command_decoder: top level with input stage and reply register
// depends on scd_pkg, scd_rx_if, scd_reply_if, scd_apb_regs, scd_decode
//
// usage
//   rx_i carries received characters, one per transaction. characters other
//   than ';' update the command state and give no reply; each ';' gives
//   exactly one reply transaction on reply_o
//   the apb port holds amplitude (address 0) and upper limit (address 4);
//   write them only while no command is in flight
// data path and throughput
//   a character is held in the input stage and then decoded into the reply
//   register, where a ';' loads its reply
//   one character per cycle while no ';' waits, set by the single decode stage
// reset
//   clears the command state, sets the frequency to 200 hz, amplitude to
//   1000 and limit to 2000, and empties both stages
// stall
//   a waiting reply holds while reply_o.ready is low; characters other than
//   ';' still pass, and a ';' waits in the input stage until the reply goes

module serial_command_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  scd_rx_if.sink                     rx_i,
  scd_reply_if.source                reply_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [scd_pkg::AddrW-1:0]  paddr,
  input  logic [scd_pkg::DataW-1:0]  pwdata,
  output logic [scd_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  scd_pkg::cfg_t              cfg;
  scd_pkg::reply_t            dec_reply;
  scd_pkg::reply_t            reply_q;
  logic                       in_valid_q, in_valid_d;
  logic [scd_pkg::ByteW-1:0]  in_byte_q;
  logic                       out_valid_q, out_valid_d;
  logic                       is_end;
  logic                       out_free;
  logic                       consume;
  logic                       load_reply;

  scd_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (consume),
    .byte_i   (in_byte_q),
    .cfg_i    (cfg),
    .is_end_o (is_end),
    .reply_o  (dec_reply)
  );

  assign out_free   = !out_valid_q || reply_o.ready;
  assign consume    = in_valid_q && (!is_end || out_free);
  assign load_reply = consume && is_end;
  assign rx_i.ready = !in_valid_q || consume;

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_i.valid && rx_i.ready) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_reply) begin
      out_valid_d = 1'b1;
    end else if (reply_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (load_reply) begin
      reply_q <= dec_reply;
    end
  end

  assign reply_o.valid           = out_valid_q;
  assign reply_o.reply_kind      = reply_q.kind;
  assign reply_o.reply_value     = reply_q.value;
  assign reply_o.synth_write     = reply_q.synth_write;
  assign reply_o.synth_frequency = reply_q.synth_frequency;

`ifndef SYNTHESIS
  a_end_gives_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_reply |=> out_valid_q)
    else $error("end of command taken without a reply");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_reply |-> out_free)
    else $error("reply register overwritten while still waiting");

  a_write_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && reply_q.synth_write |->
      (reply_q.kind == scd_pkg::KIND_FREQ_SET)
      || (reply_q.kind == scd_pkg::KIND_FREQ_REJECTED))
    else $error("synthesizer write on a reply that is not a frequency set");
`endif

endmodule

@@ verif/scd_tb_pkg.sv @@
`timescale 1ns / 1ps
// scd_tb_pkg: reply scoreboard for the serial command decoder bench
// depends on scd_pkg for field widths, character codes, register indexes and reply kinds

package scd_tb_pkg;
  import scd_pkg::*;

  localparam int unsigned ReportLimit = 10;

  class reply_scoreboard;
    logic [PosW-1:0]   char_pos;
    logic [ByteW-1:0]  cmd_char;
    logic [ByteW-1:0]  tgt_char;
    logic [ValueW-1:0] digit_acc;
    logic [ValueW-1:0] stored_freq;
    logic [CfgW-1:0]   amp_mv;
    logic [CfgW-1:0]   limit_hz;
    reply_t            expected_replies[$];
    int unsigned       mismatches;

    function new();
      amp_mv      = AmpReset;
      limit_hz    = LimReset;
      stored_freq = FreqReset;
      mismatches  = 0;
      clear_command();
    endfunction

    function void clear_command();
      char_pos  = PosFirst;
      cmd_char  = '0;
      tgt_char  = '0;
      digit_acc = '0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [DataW-1:0] data);
      case (idx)
        REG_AMPLITUDE: amp_mv = data[CfgW-1:0];
        REG_LIMIT:     limit_hz = data[CfgW-1:0];
        default: ;
      endcase
    endfunction

    function logic [CfgW-1:0] reg_value(reg_idx_e idx);
      return (idx == REG_AMPLITUDE) ? amp_mv : limit_hz;
    endfunction

    function void flag(string what, logic [31:0] exp_v, logic [31:0] act_v);
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
      end
    endfunction

    // one accepted character transaction; a ';' queues the reply it must cause
    function void note_char(logic [ByteW-1:0] ch);
      int unsigned      next_acc;
      logic [ByteW-1:0] cmd;
      logic [ByteW-1:0] tgt;
      reply_t           want;
      if (ch != ChSemi) begin
        if (ch >= ChZero && ch <= ChNine) begin
          next_acc  = 32'(digit_acc) * 10 + 32'(ch - ChZero);
          digit_acc = (next_acc > 32'(AccMax)) ? AccMax : ValueW'(next_acc);
        end
        if (char_pos == PosFirst) begin
          cmd_char = ch;
        end else if (char_pos == PosSecond) begin
          tgt_char = ch;
        end
        if (char_pos < PosRest) begin
          char_pos++;
        end
        return;
      end
      // a short command puts ';' in place of the missing letters
      cmd = (char_pos == PosFirst) ? ChSemi : cmd_char;
      tgt = (char_pos <= PosSecond) ? ChSemi : tgt_char;
      want.kind            = KIND_FORMAT_ERROR;
      want.value           = '0;
      want.synth_write     = 1'b0;
      want.synth_frequency = '0;
      if (cmd == ChSet) begin
        if (tgt == ChFreq) begin
          if (digit_acc >= FreqMin && digit_acc <= FreqMax) begin
            stored_freq = digit_acc;
            want.kind   = KIND_FREQ_SET;
          end else begin
            want.kind = KIND_FREQ_REJECTED;
          end
          want.value           = stored_freq;
          want.synth_write     = 1'b1;
          want.synth_frequency = stored_freq;
        end else if (tgt == ChAmp) begin
          want.kind = KIND_SET_AMP;
        end else if (tgt == ChLimit) begin
          want.kind = KIND_SET_LIMIT;
        end
      end else if (cmd == ChGet) begin
        if (tgt == ChFreq) begin
          want.kind  = KIND_GET_FREQ;
          want.value = stored_freq;
        end else if (tgt == ChAmp) begin
          want.kind  = KIND_GET_AMP;
          want.value = ValueW'(amp_mv);
        end else if (tgt == ChLimit) begin
          want.kind  = KIND_GET_LIMIT;
          want.value = ValueW'(limit_hz);
        end
      end
      expected_replies.push_back(want);
      clear_command();
    endfunction

    function void check_reply(logic [2:0] kind, logic [ValueW-1:0] value,
                              logic synth_write, logic [ValueW-1:0] synth_freq);
      reply_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("reply of kind %0d value %0d with none expected", kind, value);
        end
        return;
      end
      want = expected_replies.pop_front();
      if (kind !== want.kind) flag("reply kind", 32'(want.kind), 32'(kind));
      if (value !== want.value) flag("reply value", 32'(want.value), 32'(value));
      if (synth_write !== want.synth_write) begin
        flag("synth write", 32'(want.synth_write), 32'(synth_write));
      end
      if (synth_freq !== want.synth_frequency) begin
        flag("synth frequency", 32'(want.synth_frequency), 32'(synth_freq));
      end
    endfunction

    function int unsigned outstanding();
      return expected_replies.size();
    endfunction
  endclass

endpackage

@@ verif/serial_command_decoder_tb.sv @@
`timescale 1ns / 1ps
// serial_command_decoder_tb: self-checking bench, directed and random command traffic
// depends on scd_pkg, scd_rx_if, scd_reply_if, scd_tb_pkg and serial_command_decoder

module serial_command_decoder_tb;
  import scd_pkg::*;
  import scd_tb_pkg::*;

  localparam int unsigned HalfPeriod  = 10;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseBytes  = 65;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned HoldPhase   = 2;
  localparam int unsigned PausePhase  = 3;
  localparam int unsigned CycleLimit  = 200000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  scd_rx_if    rx_ch ();
  scd_reply_if reply_ch ();

  serial_command_decoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_ch),
    .reply_o (reply_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  reply_scoreboard sb = new();
  int unsigned     cycles = 0;
  int unsigned     bytes_sent = 0;
  bit              hold_req = 1'b0;
  bit              calm = 1'b0;

  always #(HalfPeriod) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (rx_ch.valid && rx_ch.ready) begin
        sb.note_char(rx_ch.rx_byte);
      end
      if (reply_ch.valid && reply_ch.ready) begin
        sb.check_reply(reply_ch.reply_kind, reply_ch.reply_value,
                       reply_ch.synth_write, reply_ch.synth_frequency);
      end
    end
  end

  // reply side: random stalls, one long hold-off on request
  initial begin : reply_sink
    int unsigned span;
    reply_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        reply_ch.ready <= 1'b0;
        for (span = 0; span < HoldCycles; span++) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        reply_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        reply_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  task automatic send_char(logic [ByteW-1:0] ch);
    if (!calm && $urandom_range(0, 7) == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= ch;
    do begin
      @(posedge clk_i);
    end while (!rx_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // stop sending and let every queued reply come out
  task automatic quiesce();
    rx_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write with random upper data bits, then read back on the next transaction
  task automatic write_reg(reg_idx_e idx, logic [CfgW-1:0] val);
    logic [DataW-1:0] word;
    word = {16'($urandom), val};
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(int'(idx) * 4);
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(idx, word);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== DataW'(sb.reg_value(idx))) begin
      sb.flag("register read-back", DataW'(sb.reg_value(idx)), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic string digit_text();
    case ($urandom_range(0, 11))
      0: return "";
      1: return "99";
      2: return "100";
      3: return "100000";
      4: return "100001";
      5: return "4294967296123";
      6: return $sformatf("00%0d", $urandom_range(100, 100000));
      7: return $sformatf("%0d", $urandom_range(0, 150));
      8: return $sformatf("%0d", $urandom_range(100001, 131071));
      default: return $sformatf("%0d", $urandom_range(100, 100000));
    endcase
  endfunction

  // mostly well-formed commands with random values, the rest noise
  task automatic send_random_command();
    logic [ByteW-1:0] chars[$];
    string            digits;
    int unsigned      at;
    if ($urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 9))
        0:          chars.push_back(ByteW'($urandom_range(0, 255)));
        1, 2, 3, 4: chars.push_back(ChGet);
        default:    chars.push_back(ChSet);
      endcase
      case ($urandom_range(0, 9))
        0:       chars.push_back(ByteW'($urandom_range(0, 255)));
        1, 2:    chars.push_back(ChAmp);
        3, 4:    chars.push_back(ChLimit);
        default: chars.push_back(ChFreq);
      endcase
      digits = digit_text();
      for (at = 0; at < digits.len(); at++) begin
        if ($urandom_range(0, 15) == 0) begin
          chars.push_back(ByteW'($urandom_range(8'h3C, 8'h7E)));
        end
        chars.push_back(digits[at]);
      end
    end else begin
      repeat ($urandom_range(0, 6)) chars.push_back(ByteW'($urandom_range(0, 255)));
    end
    chars.push_back(ChSemi);
    foreach (chars[i]) send_char(chars[i]);
  endtask

  initial begin : stimulus
    int unsigned      phase;
    int unsigned      phase_start;
    bit               paused;
    logic [CfgW-1:0]  amp_v;
    logic [CfgW-1:0]  lim_v;
    rst_ni        <= 1'b0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values, short commands, range edges, saturation, stray bytes
    send_text("GF;GA;GL;");
    send_text(";S;SF;");
    send_text("SF99;SF100;SF100000;SF100001;");
    send_text("SF99999999999;SA5;SL7;");
    send_text("5F250;SFx1y2z3;GF;sf500;XA;");
    send_text("SF500;S;GF1;");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(ChSemi);
    quiesce();

    paused = 1'b0;
    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin
          amp_v = '0;
          lim_v = '1;
        end
        1: begin
          amp_v = '1;
          lim_v = '0;
        end
        default: begin
          amp_v = 16'($urandom);
          lim_v = 16'($urandom);
        end
      endcase
      write_reg(REG_AMPLITUDE, amp_v);
      write_reg(REG_LIMIT, lim_v);
      if (phase == HoldPhase) hold_req = 1'b1;
      if (phase == NumPhases - 1) calm = 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        send_random_command();
        if (phase == PausePhase && !paused && bytes_sent - phase_start > PhaseBytes / 2) begin
          quiesce();
          paused = 1'b1;
        end
      end
      quiesce();
    end

    repeat (2 * DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/scd_pkg.sv
rtl/scd_rx_if.sv
rtl/scd_reply_if.sv
rtl/scd_apb_regs.sv
rtl/scd_decode.sv
rtl/serial_command_decoder.sv
verif/scd_tb_pkg.sv
verif/serial_command_decoder_tb.sv
